/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define PPSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define PPSR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PPSR_ASSERT(lbl, prop, msg)
`define PPSR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/ppsr_pkg.sv */
// ----------------------------------------------------------------------------
// ppsr_pkg
// Sizes, types and helpers of the per-peer sequence reorder block.
// ----------------------------------------------------------------------------
package ppsr_pkg;

  localparam int unsigned NUM_PEERS   = 16;
  localparam int unsigned WINDOW      = 16;
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned NUM_SLOTS  = NUM_PEERS * WINDOW;
  localparam int unsigned PIDX_W     = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int unsigned PEER_SPAN  = 2 ** PIDX_W;
  localparam int unsigned RES_W      = $clog2(WINDOW);
  localparam int unsigned CNT_W      = $clog2(WINDOW);
  localparam int unsigned SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SEQ_W      = 32;
  // One expected-number word holds the number and its residue modulo WINDOW.
  localparam int unsigned EXP_WORD_W = SEQ_W + RES_W;

  typedef enum logic [1:0] {
    STAT_DELIVERED = 2'd0,
    STAT_BEYOND    = 2'd1,
    STAT_STALE     = 2'd2,
    STAT_DUPLICATE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN
  } state_e;

  typedef logic [PIDX_W-1:0]      pidx_t;
  typedef logic [RES_W-1:0]       res_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  // Slot of a peer's message whose number has the given residue.
  function automatic slot_t slot_addr(input pidx_t p, input res_t r);
    int unsigned idx;
    idx = int'(p) * WINDOW + int'(r);
    return SLOT_W'(idx);
  endfunction

  // Residue of a number plus one, wrapping at WINDOW.
  function automatic res_t res_inc(input res_t r);
    res_t nxt;
    if (r == RES_W'(WINDOW - 1)) begin
      nxt = '0;
    end else begin
      nxt = r + 1'b1;
    end
    return nxt;
  endfunction

endpackage

/* rtl/ppsr_ram.sv */
// ----------------------------------------------------------------------------
// ppsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppsr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/per_peer_sequence_reorder.sv */
// ----------------------------------------------------------------------------
// per_peer_sequence_reorder
// Restores message order independently for each sending peer.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low; it
// carries a peer, a 32-bit sequence number and a message handle. A request
// whose number is the peer's expected number is released at once, followed by
// every stored message that now continues the sequence, one result per cycle,
// the final one marked by last_o. An early request inside the window is parked
// and gives no result. A duplicate, stale, out-of-window or out-of-range
// request gives a single drop result with last_o set. Results appear for one
// cycle under out_strobe_o and cannot be held off, so the receiver must take
// every strobe. A request is evaluated in the cycle after its accepting edge,
// and its first result is on the ports in the cycle after that. busy is high
// while the request is evaluated and while each stored message that it
// releases is read out, and no request is accepted while busy is high. The
// steps are the registered read of the peer's expected number from its
// memory, issued at the accepting edge, followed by the evaluation and
// write-back; the walk over stored messages reads the handle memory one slot
// per cycle. Slot and expected-number valid bits are cleared by reset, so no
// clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_peer_sequence_reorder
  import ppsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  peer_i,
  input  logic [31:0] seq_i,
  input  logic [15:0] message_handle_i,
  output logic        out_strobe_o,
  output logic [3:0]  out_peer_o,
  output logic [31:0] out_seq_o,
  output logic [15:0] out_handle_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // Control state.
  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Captured request and walk position.
  logic [3:0]       peer_q;
  logic [SEQ_W-1:0] seq_q;
  handle_t          handle_q;
  logic [SEQ_W-1:0] cur_seq_q, cur_seq_d;
  res_t             cur_res_q, cur_res_d;

  // Valid bits; an expected number that is not valid reads as zero.
  logic [NUM_SLOTS-1:0] slot_valid_q;
  logic [PEER_SPAN-1:0] exp_valid_q;

  // Output register.
  logic             out_strobe_q, out_strobe_d;
  logic [3:0]       out_peer_q, out_peer_d;
  logic [SEQ_W-1:0] out_seq_q, out_seq_d;
  handle_t          out_handle_q, out_handle_d;
  status_e          status_q, status_d;
  logic             last_q, last_d;

  // Memory ports and valid-bit updates.
  logic                  exp_we;
  logic [EXP_WORD_W-1:0] exp_wdata;
  logic                  exp_re;
  logic [EXP_WORD_W-1:0] exp_rdata;
  logic                  hdl_we;
  slot_t                 hdl_waddr;
  logic                  hdl_re;
  slot_t                 hdl_raddr;
  handle_t               hdl_rdata;
  logic                  slot_set;
  slot_t                 slot_set_idx;
  logic                  slot_clr;
  slot_t                 slot_clr_idx;

  // Evaluation terms.
  pidx_t            pidx;
  logic             peer_ok;
  logic [SEQ_W-1:0] exp_num;
  res_t             exp_res;
  logic [SEQ_W-1:0] seq_delta;
  logic [RES_W:0]   res_sum;
  res_t             seq_res;
  logic [SEQ_W-1:0] nxt_seq;
  res_t             nxt_res;
  slot_t            nxt_slot;
  slot_t            cur_slot;

  assign pidx      = PIDX_W'(peer_q);
  assign peer_ok   = (32'(peer_q) < 32'(NUM_PEERS));
  assign exp_num   = exp_valid_q[pidx] ? exp_rdata[SEQ_W-1:0] : '0;
  assign exp_res   = exp_valid_q[pidx] ? exp_rdata[EXP_WORD_W-1:SEQ_W] : '0;
  assign seq_delta = seq_q - exp_num;

  // Residue of an early number: the expected residue plus the distance, which
  // is below WINDOW here, so one conditional subtract suffices.
  assign res_sum = (RES_W+1)'(exp_res) + (RES_W+1)'(seq_delta[RES_W-1:0]);
  assign seq_res = (res_sum >= (RES_W+1)'(WINDOW)) ?
                   RES_W'(res_sum - (RES_W+1)'(WINDOW)) : RES_W'(res_sum);

  // Next number to look for: one past the expected number on arrival, one past
  // the current slot while walking.
  assign nxt_seq  = (state_q == S_DRAIN) ? cur_seq_q + 1'b1 : exp_num + 1'b1;
  assign nxt_res  = (state_q == S_DRAIN) ? res_inc(cur_res_q) : res_inc(exp_res);
  assign nxt_slot = slot_addr(pidx, nxt_res);
  assign cur_slot = slot_addr(pidx, cur_res_q);

  assign exp_re    = start && !busy;
  assign exp_wdata = {nxt_res, nxt_seq};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cur_seq_d    = cur_seq_q;
    cur_res_d    = cur_res_q;
    out_strobe_d = 1'b0;
    out_peer_d   = peer_q;
    out_seq_d    = seq_q;
    out_handle_d = handle_q;
    status_d     = STAT_DELIVERED;
    last_d       = 1'b1;
    exp_we       = 1'b0;
    hdl_we       = 1'b0;
    hdl_waddr    = slot_addr(pidx, seq_res);
    hdl_re       = 1'b0;
    hdl_raddr    = nxt_slot;
    slot_set     = 1'b0;
    slot_set_idx = slot_addr(pidx, seq_res);
    slot_clr     = 1'b0;
    slot_clr_idx = cur_slot;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        state_d = S_IDLE;
        priority if (!peer_ok) begin
          out_strobe_d = 1'b1;
          status_d     = STAT_BEYOND;
        end else if (seq_delta == '0) begin
          out_strobe_d = 1'b1;
          if (slot_valid_q[nxt_slot]) begin
            // A stored message continues the sequence: start the walk.
            last_d    = 1'b0;
            hdl_re    = 1'b1;
            cur_seq_d = nxt_seq;
            cur_res_d = nxt_res;
            cnt_d     = CNT_W'(1);
            state_d   = S_DRAIN;
          end else begin
            exp_we = 1'b1;
          end
        end else if (seq_delta < SEQ_W'(WINDOW)) begin
          if (slot_valid_q[slot_set_idx]) begin
            out_strobe_d = 1'b1;
            status_d     = STAT_DUPLICATE;
          end else begin
            slot_set = 1'b1;
            hdl_we   = 1'b1;
          end
        end else if (seq_delta[SEQ_W-1]) begin
          out_strobe_d = 1'b1;
          status_d     = STAT_STALE;
        end else begin
          out_strobe_d = 1'b1;
          status_d     = STAT_BEYOND;
        end
      end

      S_DRAIN: begin
        out_strobe_d = 1'b1;
        out_seq_d    = cur_seq_q;
        out_handle_d = hdl_rdata;
        slot_clr     = 1'b1;
        if ((cnt_q != CNT_W'(WINDOW - 1)) && slot_valid_q[nxt_slot]) begin
          last_d    = 1'b0;
          hdl_re    = 1'b1;
          cur_seq_d = nxt_seq;
          cur_res_d = nxt_res;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          exp_we  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      out_strobe_q <= 1'b0;
      slot_valid_q <= '0;
      exp_valid_q  <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_strobe_q <= out_strobe_d;
      if (slot_set) begin
        slot_valid_q[slot_set_idx] <= 1'b1;
      end
      if (slot_clr) begin
        slot_valid_q[slot_clr_idx] <= 1'b0;
      end
      if (exp_we) begin
        exp_valid_q[pidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      peer_q   <= peer_i;
      seq_q    <= seq_i;
      handle_q <= HANDLE_BITS'(message_handle_i);
    end
    cur_seq_q    <= cur_seq_d;
    cur_res_q    <= cur_res_d;
    out_peer_q   <= out_peer_d;
    out_seq_q    <= out_seq_d;
    out_handle_q <= out_handle_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  // Expected number and its residue, one word per peer.
  ppsr_ram #(
    .WIDTH (EXP_WORD_W),
    .DEPTH (NUM_PEERS),
    .ADDR_W(PIDX_W)
  ) u_exp_ram (
    .clk_i  (clk_i),
    .we_i   (exp_we),
    .waddr_i(pidx),
    .wdata_i(exp_wdata),
    .re_i   (exp_re),
    .raddr_i(PIDX_W'(peer_i)),
    .rdata_o(exp_rdata)
  );

  // Handles of parked messages, one slot per peer and residue.
  ppsr_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(SLOT_W)
  ) u_hdl_ram (
    .clk_i  (clk_i),
    .we_i   (hdl_we),
    .waddr_i(hdl_waddr),
    .wdata_i(handle_q),
    .re_i   (hdl_re),
    .raddr_i(hdl_raddr),
    .rdata_o(hdl_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign out_strobe_o = out_strobe_q;
  assign out_peer_o   = out_peer_q;
  assign out_seq_o    = out_seq_q;
  assign out_handle_o = 16'(out_handle_q);
  assign status_o     = status_q;
  assign last_o       = last_q;

  `PPSR_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
  `PPSR_ASSERT(a_drop_last, out_strobe_o && (status_o != STAT_DELIVERED) |-> last_o,
               "drop result without last mark")
  `PPSR_ASSERT(a_burst_cont, out_strobe_o && !last_o |=> out_strobe_o,
               "release burst ended without a last mark")
  `PPSR_ASSERT(a_walk_valid, (state_q == S_DRAIN) |-> slot_valid_q[cur_slot],
               "walk reached an empty slot")
  `PPSR_ASSERT_NEVER(a_idle_strobe, !$past(busy) && out_strobe_o,
                     "result strobe without a request in progress")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-peer sequence reorder block. Directed
// requests cover in-order release, a full drain, every drop kind and the
// window and half-range boundaries. Random traffic follows with shuffled
// per-peer runs, some of them with holes, plus noise. Every accepted request
// is run through a local predictor, and each strobed result is compared field
// by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import ppsr_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  // The slowest legal stretch is a long sender gap plus a full drain.
  localparam int unsigned IDLE_LIMIT  = 2000;
  // Quiet cycles after the last predicted result, to catch stray strobes.
  localparam int unsigned TAIL_CYCLES = 2 * WINDOW + 8;
  localparam int unsigned MAX_PRINTS  = 40;

  // One predicted result, as it should appear under out_strobe_o.
  typedef struct {
    logic [3:0]  peer;
    logic [31:0] seq;
    logic [15:0] handle;
    status_e     status;
    logic        last;
  } release_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [3:0]  peer_i           = '0;
  logic [31:0] seq_i            = '0;
  logic [15:0] message_handle_i = '0;
  logic        out_strobe_o;
  logic [3:0]  out_peer_o;
  logic [31:0] out_seq_o;
  logic [15:0] out_handle_o;
  logic [1:0]  status_o;
  logic        last_o;

  // Predicted results still waiting to come out, oldest first.
  release_t    release_q[$];

  // Predictor state: next in-order number per peer and the parked messages.
  logic [31:0] next_seq[NUM_PEERS];
  logic        slot_held[NUM_SLOTS];
  handle_t     slot_hdl[NUM_SLOTS];

  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  int unsigned req_count   = 0;

  per_peer_sequence_reorder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .peer_i           (peer_i),
    .seq_i            (seq_i),
    .message_handle_i (message_handle_i),
    .out_strobe_o     (out_strobe_o),
    .out_peer_o       (out_peer_o),
    .out_seq_o        (out_seq_o),
    .out_handle_o     (out_handle_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) begin
      $display("%0t mismatch: %s", $time, what);
    end
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_predictor();
    for (int unsigned i = 0; i < NUM_PEERS; i++) begin
      next_seq[i] = '0;
    end
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      slot_held[i] = 1'b0;
      slot_hdl[i]  = '0;
    end
  endfunction

  // A message with number s for peer p is parked in slot p*WINDOW + s mod WINDOW.
  function automatic int unsigned slot_index(input logic [3:0] p, input logic [31:0] s);
    return int'(p) * WINDOW + int'(s % WINDOW);
  endfunction

  function automatic void queue_result(input logic [3:0] p, input logic [31:0] s,
                                       input handle_t h, input status_e st,
                                       input logic lst);
    release_t r;
    r.peer   = p;
    r.seq    = s;
    r.handle = 16'(h);
    r.status = st;
    r.last   = lst;
    release_q.push_back(r);
  endfunction

  // Works out what one accepted request releases or drops, and updates the
  // predictor state the same way the block must.
  function automatic void predict_release(input logic [3:0] p, input logic [31:0] s,
                                          input logic [15:0] h);
    logic [31:0] delta;
    logic [31:0] nxt;
    int unsigned sl;
    handle_t     hk;
    hk = handle_t'(h);
    if (int'(p) >= NUM_PEERS) begin
      queue_result(p, s, hk, STAT_BEYOND, 1'b1);
      return;
    end
    delta = s - next_seq[p];
    if (delta == 0) begin
      // In order: release this one, then walk the parked run that follows it.
      queue_result(p, s, hk, STAT_DELIVERED, 1'b0);
      nxt = s + 1;
      for (int unsigned i = 1; i < WINDOW; i++) begin
        sl = slot_index(p, nxt);
        if (!slot_held[sl]) break;
        slot_held[sl] = 1'b0;
        queue_result(p, nxt, slot_hdl[sl], STAT_DELIVERED, 1'b0);
        nxt = nxt + 1;
      end
      next_seq[p] = nxt;
      release_q[release_q.size() - 1].last = 1'b1;
    end else if (delta < WINDOW) begin
      sl = slot_index(p, s);
      if (slot_held[sl]) begin
        // Duplicate: the parked message stays, the new one is dropped.
        queue_result(p, s, hk, STAT_DUPLICATE, 1'b1);
      end else begin
        slot_held[sl] = 1'b1;
        slot_hdl[sl]  = hk;
      end
    end else if (delta[31]) begin
      // Half the number space or more ahead means the number lies behind.
      queue_result(p, s, hk, STAT_STALE, 1'b1);
    end else begin
      queue_result(p, s, hk, STAT_BEYOND, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Issues one request and returns at the edge that accepted it. start is left
  // high, so a following request with no gap goes out without a bubble.
  task automatic send_req(input logic [3:0] p, input logic [31:0] s,
                          input logic [15:0] h, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    peer_i           <= p;
    seq_i            <= s;
    message_handle_i <= h;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_release(p, s, h);
    req_count++;
  endtask

  // Holds requests back until every predicted result has been seen.
  task automatic wait_all_released();
    start <= 1'b0;
    do @(posedge clk_i); while (release_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    release_t want;
    if (rst_ni && out_strobe_o === 1'b1) begin
      if (release_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result peer %0d seq %0h handle %0h",
                                  out_peer_o, out_seq_o, out_handle_o));
      end else begin
        want = release_q.pop_front();
        if (out_peer_o !== want.peer)
          report_mismatch($sformatf("peer %0d, wanted %0d (seq %0h)",
                                    out_peer_o, want.peer, want.seq));
        if (out_seq_o !== want.seq)
          report_mismatch($sformatf("seq %0h, wanted %0h (peer %0d)",
                                    out_seq_o, want.seq, want.peer));
        if (out_handle_o !== want.handle)
          report_mismatch($sformatf("handle %0h, wanted %0h (peer %0d seq %0h)",
                                    out_handle_o, want.handle, want.peer, want.seq));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, wanted %s (peer %0d seq %0h)",
                                    status_o, want.status.name(), want.peer, want.seq));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b (peer %0d seq %0h)",
                                    last_o, want.last, want.peer, want.seq));
      end
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || out_strobe_o === 1'b1 || (start && busy === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain in-order delivery with the handle extremes.
  task automatic test_in_order();
    send_req(4'd0, 32'd0, 16'h0000, 0);
    send_req(4'd0, 32'd1, 16'hFFFF, pick_gap());
  endtask

  // The last peer parks every number of the window after its head, in reverse
  // order starting at the far edge, then the missing head releases all of them at once.
  task automatic test_full_drain();
    for (int unsigned i = WINDOW - 1; i >= 1; i--) begin
      send_req(4'd15, 32'(i), 16'($urandom), pick_gap());
    end
    send_req(4'd15, 32'd0, 16'hFFFF, pick_gap());
  endtask

  // Every drop kind, and the boundaries between window, beyond and stale.
  task automatic test_drops();
    logic [31:0] head;
    head = next_seq[15];
    send_req(4'd15, head + 2, 16'h1234, 0);
    send_req(4'd15, head + 2, 16'h4321, pick_gap());                  // duplicate
    send_req(4'd15, head + WINDOW, 16'hA5A5, pick_gap());             // just past window
    send_req(4'd15, head + 32'h7FFF_FFFF, 16'h5A5A, pick_gap());      // farthest ahead
    send_req(4'd15, head + 32'h8000_0000, 16'h0F0F, pick_gap());      // nearest behind
    send_req(4'd0, 32'hFFFF_FFFF, 16'hF0F0, pick_gap());              // one behind zero
    send_req(4'd15, head, 16'h00FF, pick_gap());
    send_req(4'd15, head + 1, 16'hFF00, pick_gap());                  // drains the parked one
  endtask

  // Random traffic. Most of it is runs of consecutive numbers for one peer,
  // shuffled, starting at that peer's next in-order number, so messages are
  // parked and then drained. Some runs leave a hole that a later run fills.
  // The rest is noise: anywhere in the number space, the half-range edges,
  // just behind, inside the window and just past it.
  task automatic test_random_traffic(input int unsigned n_items);
    logic [3:0]  p;
    logic [31:0] base;
    logic [31:0] s;
    logic [31:0] tmp;
    logic [31:0] run[$];
    int unsigned len;
    int unsigned hole;
    int unsigned k;
    int unsigned kind;
    int unsigned stop_at;
    int unsigned halfway;
    bit          quiet;
    bit          paused;
    stop_at = req_count + n_items;
    halfway = req_count + n_items / 2;
    paused  = 1'b0;
    while (req_count < stop_at) begin
      if (!paused && req_count >= halfway) begin
        wait_all_released();
        paused = 1'b1;
      end
      p     = 4'($urandom_range(0, NUM_PEERS - 1));
      base  = next_seq[p];
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(WINDOW / 2 + 1, WINDOW);
        end else begin
          len = $urandom_range(1, WINDOW / 2);
        end
        hole = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
        run.delete();
        for (int unsigned j = 0; j < len; j++) begin
          if (j != hole) run.push_back(base + j);
        end
        for (int unsigned j = run.size(); j > 1; j--) begin
          k          = $urandom_range(0, j - 1);
          tmp        = run[k];
          run[k]     = run[j - 1];
          run[j - 1] = tmp;
        end
        for (int unsigned j = 0; j < run.size(); j++) begin
          send_req(p, run[j], 16'($urandom), quiet ? 0 : pick_gap());
        end
      end else begin
        case (kind)
          7: begin
            if ($urandom_range(0, 3) == 0) begin
              s = base + ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            end else begin
              s = $urandom;
            end
          end
          8: s = base - 32'($urandom_range(1, 3 * WINDOW));
          default: begin
            if ($urandom_range(0, 1)) begin
              s = base + 32'($urandom_range(1, WINDOW - 1));
            end else begin
              s = base + 32'($urandom_range(WINDOW, WINDOW + 3));
            end
          end
        endcase
        send_req(p, s, 16'($urandom), quiet ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    clear_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_in_order();
    test_full_drain();
    test_drops();
    test_random_traffic(345);

    wait_all_released();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (release_q.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never came", release_q.size()));
    end
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ppsr_pkg.sv
rtl/ppsr_ram.sv
rtl/per_peer_sequence_reorder.sv
tb/sv/tb_top.sv
